>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for the RTL, included by the top-level transmitter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// check only outside reset
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> hw/rtl/dmxtx_pkg.sv
// ---------------------------------------------------------------------------
// DMX512 transmitter package
// Sizes, codes and command/result records shared by the transmitter modules.
// ---------------------------------------------------------------------------
package dmxtx_pkg;

  localparam int CHANNELS  = 512;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEN_W     = $clog2(CHANNELS + 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BREAK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAB   = 1'b1;

  localparam logic [7:0] BREAK_RST = 8'd133;
  localparam logic [7:0] MAB_RST   = 8'd13;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_RANGE  = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_BAD_VALUE   = 2'd2,
    ST_STALL       = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_OFF   = 6'b000001,
    PH_NEW   = 6'b000010,
    PH_BYTES = 6'b000100,
    PH_END   = 6'b001000,
    PH_BREAK = 6'b010000,
    PH_MAB   = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_RUN   = 3'b010,
    B_READ  = 3'b100
  } bstate_t;

  typedef struct packed {
    mode_t            mode;
    status_t          status;
    logic [CH_W-1:0]  chan;
    logic [7:0]       value;
    logic [LEN_W-1:0] last;
    logic             zero_count;
    logic             uart_empty;
    logic             uart_done;
  } cmd_t;

  typedef struct packed {
    logic       line_low;
    logic       uart_enable;
    logic [7:0] send_byte;
    logic       send_valid;
    logic       range_done;
    status_t    status;
  } res_t;

endpackage

>>> hw/rtl/dmxtx_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dmxtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/dmxtx_front.sv
// ---------------------------------------------------------------------------
// Transmitter front end
// Accept input beats, check bounds and values, and build queue commands.
// ---------------------------------------------------------------------------
module dmxtx_front import dmxtx_pkg::*; (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,
  input  logic [1:0]      s_axis_tuser,
  input  logic            clearing,
  input  logic            q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [15:0] channel;
  logic [7:0]  value;
  logic [7:0]  value_high;
  logic [15:0] count;
  logic [15:0] count_limit;
  logic [16:0] range_sum;
  mode_t       mode;

  assign mode        = mode_t'(s_axis_tuser);
  assign channel     = s_axis_tdata[15:0];
  assign value       = s_axis_tdata[23:16];
  assign value_high  = s_axis_tdata[31:24];
  assign count       = s_axis_tdata[47:32];
  assign count_limit = s_axis_tdata[63:48];
  assign range_sum   = {1'b0, channel} + {1'b0, count};

  assign s_axis_tready = !q_full && !clearing;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_cmd            = '0;
    q_cmd.mode       = mode;
    q_cmd.status     = ST_OK;
    q_cmd.chan       = channel[CH_W-1:0];
    q_cmd.value      = value;
    q_cmd.last       = range_sum[LEN_W-1:0];
    q_cmd.zero_count = (count == 16'd0);
    q_cmd.uart_empty = s_axis_tdata[64];
    q_cmd.uart_done  = s_axis_tdata[65];
    case (mode)
      MODE_SINGLE: begin
        if (channel > 16'(CHANNELS - 1)) begin
          q_cmd.status = ST_BAD_CHANNEL;
        end else if (value_high != 8'd0) begin
          q_cmd.status = ST_BAD_VALUE;
        end
      end
      MODE_RANGE: begin
        if (count > count_limit) begin
          q_cmd.status = ST_BAD_VALUE;
        end else if (channel > 16'(CHANNELS - 1) || range_sum > 17'(CHANNELS)) begin
          q_cmd.status = ST_BAD_CHANNEL;
        end
      end
      default: begin
        q_cmd.status = ST_OK;
      end
    endcase
  end

endmodule

>>> hw/rtl/dmxtx_queue.sv
// ---------------------------------------------------------------------------
// Command queue
// Short FIFO of checked commands between the front and back ends.
// ---------------------------------------------------------------------------
module dmxtx_queue import dmxtx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] level;
  logic [QCNT_W-1:0] level_next;

  assign full    = (level == QCNT_W'(QDEPTH));
  assign empty   = (level == '0);
  assign pop_cmd = slots[rd_ptr];

  always_comb begin
    level_next = level;
    if (push && !pop) begin
      level_next = level + 1'b1;
    end else if (pop && !push) begin
      level_next = level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/dmxtx_back.sv
// ---------------------------------------------------------------------------
// Transmitter back end
// Execute commands against the channel store and drive the frame sequence.
// ---------------------------------------------------------------------------
module dmxtx_back import dmxtx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 q_empty,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);

  bstate_t          bstate, bstate_next;
  logic [CH_W-1:0]  clr_addr, clr_addr_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] send_index, send_index_next;
  phase_t           phase, phase_next;
  logic             range_open, range_open_next;
  logic [LEN_W-1:0] range_pos, range_pos_next;
  logic [LEN_W-1:0] range_end, range_end_next;
  logic [7:0]       timer, timer_next;
  logic [7:0]       break_len;
  logic [7:0]       mab_len;
  logic             res_valid_next;
  res_t             res_next;

  logic             slot_free;
  logic             mark;
  logic [LEN_W-1:0] upto;
  logic [LEN_W-1:0] pos_inc;
  logic [7:0]       timer_dec;
  logic             ram_we;
  logic [CH_W-1:0]  ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  dmxtx_ram #(
    .WIDTH(8),
    .DEPTH(CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(send_index[CH_W-1:0]),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign clearing  = (bstate == B_CLEAR);
  assign slot_free = !res_valid || res_ready;
  assign q_pop     = (bstate == B_RUN) && !q_empty && slot_free;
  assign pos_inc   = range_pos + 1'b1;
  assign timer_dec = timer - 8'd1;

  always_comb begin
    bstate_next       = bstate;
    clr_addr_next     = clr_addr;
    frame_length_next = frame_length;
    send_index_next   = send_index;
    phase_next        = phase;
    range_open_next   = range_open;
    range_pos_next    = range_pos;
    range_end_next    = range_end;
    timer_next        = timer;
    res_valid_next    = res_valid && !res_ready;
    res_next          = res;
    mark              = 1'b0;
    upto              = '0;
    ram_we            = 1'b0;
    ram_waddr         = clr_addr;
    ram_wdata         = 8'd0;

    case (bstate)
      B_CLEAR: begin
        ram_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == CH_W'(CHANNELS - 1)) begin
          bstate_next = B_RUN;
        end
      end
      B_RUN: begin
        if (q_pop) begin
          res_next            = '0;
          res_next.status     = q_cmd.status;
          res_valid_next      = 1'b1;
          case (q_cmd.mode)
            MODE_SINGLE: begin
              if (q_cmd.status == ST_OK) begin
                ram_we    = 1'b1;
                ram_waddr = q_cmd.chan;
                ram_wdata = q_cmd.value;
                mark      = 1'b1;
                upto      = LEN_W'(q_cmd.chan) + 1'b1;
              end
            end
            MODE_RANGE: begin
              if (q_cmd.status != ST_OK) begin
                range_open_next = 1'b0;
                range_pos_next  = '0;
                range_end_next  = '0;
              end else begin
                range_open_next     = !q_cmd.zero_count;
                range_pos_next      = LEN_W'(q_cmd.chan);
                range_end_next      = q_cmd.last;
                res_next.range_done = q_cmd.zero_count;
              end
            end
            MODE_DATA: begin
              if (!range_open) begin
                res_next.status = ST_STALL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = range_pos[CH_W-1:0];
                ram_wdata      = q_cmd.value;
                range_pos_next = pos_inc;
                mark           = 1'b1;
                upto           = pos_inc;
                if (pos_inc >= range_end) begin
                  range_open_next     = 1'b0;
                  res_next.range_done = 1'b1;
                end
              end
            end
            MODE_TICK: begin
              if (frame_length != '0) begin
                case (phase)
                  PH_NEW: begin
                    send_index_next     = '0;
                    res_next.send_valid = 1'b1;
                    phase_next          = PH_BYTES;
                  end
                  PH_BYTES: begin
                    if (q_cmd.uart_empty) begin
                      if (send_index < frame_length) begin
                        send_index_next     = send_index + 1'b1;
                        res_next.send_valid = 1'b1;
                        res_valid_next      = 1'b0;
                        bstate_next         = B_READ;
                      end else begin
                        phase_next = PH_END;
                        if (q_cmd.uart_done) begin
                          timer_next = break_len;
                          phase_next = PH_BREAK;
                        end
                      end
                    end
                  end
                  PH_END: begin
                    if (q_cmd.uart_done) begin
                      timer_next = break_len;
                      phase_next = PH_BREAK;
                    end
                  end
                  PH_BREAK: begin
                    timer_next = timer_dec;
                    if (timer_dec == 8'd0) begin
                      timer_next = mab_len;
                      phase_next = PH_MAB;
                    end
                  end
                  PH_MAB: begin
                    timer_next = timer_dec;
                    if (timer_dec == 8'd0) begin
                      phase_next = PH_NEW;
                    end
                  end
                  default: begin
                    phase_next = phase;
                  end
                endcase
              end
            end
            default: begin
              res_next.status = ST_OK;
            end
          endcase
          if (mark) begin
            if (upto > frame_length) begin
              frame_length_next = upto;
            end
            if (phase == PH_OFF) begin
              phase_next = PH_NEW;
            end
          end
          res_next.uart_enable = (phase_next == PH_BYTES) || (phase_next == PH_END);
          res_next.line_low    = (phase_next == PH_BREAK);
        end
      end
      B_READ: begin
        res_next.send_byte = ram_rdata;
        res_valid_next     = 1'b1;
        bstate_next        = B_RUN;
      end
      default: begin
        bstate_next = B_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate       <= B_CLEAR;
      clr_addr     <= '0;
      frame_length <= '0;
      send_index   <= '0;
      phase        <= PH_OFF;
      range_open   <= 1'b0;
      range_pos    <= '0;
      range_end    <= '0;
      timer        <= 8'd0;
      res_valid    <= 1'b0;
    end else begin
      bstate       <= bstate_next;
      clr_addr     <= clr_addr_next;
      frame_length <= frame_length_next;
      send_index   <= send_index_next;
      phase        <= phase_next;
      range_open   <= range_open_next;
      range_pos    <= range_pos_next;
      range_end    <= range_end_next;
      timer        <= timer_next;
      res_valid    <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_len <= BREAK_RST;
      mab_len   <= MAB_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BREAK: break_len <= cfg_data;
        CFG_MAB:   mab_len   <= cfg_data;
        default:   break_len <= break_len;
      endcase
    end
  end

endmodule

>>> hw/rtl/dmx512_frame_transmitter.sv
// Path: input beat -> command queue slot -> result register; a tick that sends a channel
// byte also holds the back end in the B_READ state (registered read of the channel store).
// Throughput: one beat per cycle while the queue has room and results are taken.
// Reset: control state clears at once, then a clearing pass zeroes the channel store
// with s_axis_tready low; configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// DMX512 frame transmitter
// Channel buffer with host writes and tick-driven frame sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmx512_frame_transmitter import dmxtx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // channel, value, value_high, count, count_limit, uart_empty, uart_done, zero fill
  input  logic [IN_W-1:0]      s_axis_tdata,
  // mode
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status, range_done, send_valid, send_byte, uart_enable, line_low, zero fill
  output logic [OUT_W-1:0]     m_axis_tdata
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic clearing;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  res_t res;

  dmxtx_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  dmxtx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (pop_cmd),
    .empty   (q_empty)
  );

  dmxtx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res      (res)
  );

  assign m_axis_tdata = {{(OUT_W - $bits(res_t)){1'b0}}, res};

  `ASSERT_ALWAYS(a_reset_blocks_input, clk, rst |=> !s_axis_tready, "input taken after reset")
  `ASSERT_RUN(a_send_enables_uart, clk, rst,
    (m_axis_tvalid && res.send_valid) |-> res.uart_enable, "byte sent without uart enable")
  `ASSERT_RUN(a_break_excl, clk, rst,
    m_axis_tvalid |-> !(res.line_low && res.uart_enable), "break with uart enabled")
  `ASSERT_RUN(a_pop_needs_entry, clk, rst,
    q_pop |-> (!q_empty && !clearing), "pop from empty queue")

endmodule
